FILE: hw/rtl/hps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the haptic pattern sequencer
// Frame table geometry, field widths, request and mode codes, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int MAX_FRAMES  = 32;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);
    localparam int N_W         = $clog2(MAX_FRAMES + 1);
    localparam int TICK_W      = 16;
    localparam int LEVEL_W     = 32;
    localparam int ELAPSED_W   = 40;
    localparam int DELTA_W     = 32;
    localparam int LOOP_W      = 16;
    localparam int SPAN_W      = 32;
    localparam int FCOUNT_W    = 6;
    localparam int REQ_W       = 3;
    localparam int FIDX_W      = 5;
    // sum of all frame ticks fits here
    localparam int TOTAL_W     = TICK_W + N_W;
    localparam int PROD_W      = TOTAL_W + LOOP_W;
    localparam int CMP_W       = ELAPSED_W + PROD_W + SPAN_W;
    localparam int DCNT_W      = $clog2(ELAPSED_W);
    localparam int CNT_W       = (N_W > DCNT_W) ? N_W : DCNT_W;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_PLAY    = 3'd2,
        REQ_PAUSE   = 3'd3,
        REQ_STOP    = 3'd4,
        REQ_RESTART = 3'd5,
        REQ_SEEK    = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        MODE_LOOP   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_LOOP_N = 2'd2,
        MODE_SPAN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_FRAME_COUNT = 2'd0,
        REG_PLAY_MODE   = 2'd1,
        REG_LOOP_COUNT  = 2'd2,
        REG_SPAN_TICKS  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic              accept;
        logic              walk_rd;
        logic              walk_find;
        logic [ADDR_W-1:0] rd_addr;
        logic              clr_acc;
        logic              mul;
        logic              div_init;
        logic              div_step;
        logic              find_init;
        logic              set_silent;
        logic              silent_done;
        logic              seek_set;
        logic              lv_take;
        logic              found_take;
        logic              out_load;
    } hps_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic past_end;
    } hps_status_t;

endpackage : hps_pkg
`default_nettype wire

FILE: hw/rtl/haptic_pattern_sequencer.sv
// Steps: load/play/pause go straight to the response; stop/restart read frame 0
//   levels if any frame is active; seek sums the frames below idx, reads idx levels;
//   advance sums n frame ticks, then, unless finished, takes the remainder and searches.
// Throughput: one item at a time; the single-port frame table walk and the
//   bit-serial remainder set the advance time. A result may wait in the output
//   register while the next item is taken. Reset clears player and registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer: motor vibration pattern player
// APB register file, controller and datapath of the frame sequencer.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hps_pkg::APB_AW-1:0]     paddr,
    input  wire logic [hps_pkg::APB_DW-1:0]     pwdata,
    output logic      [hps_pkg::APB_DW-1:0]     prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [hps_pkg::REQ_W-1:0]      req_type,
    input  wire logic [hps_pkg::FIDX_W-1:0]     frame_index,
    input  wire logic [hps_pkg::TICK_W-1:0]     frame_ticks,
    input  wire logic [hps_pkg::LEVEL_W-1:0]    frame_levels,
    input  wire logic [hps_pkg::DELTA_W-1:0]    delta_ticks,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [hps_pkg::LEVEL_W-1:0]    motor_levels,
    output logic                                finished
);
    import hps_pkg::*;

    logic [FCOUNT_W-1:0] frame_count_reg;
    logic [1:0]          play_mode_reg;
    logic [LOOP_W-1:0]   loop_count_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [N_W-1:0]      active_n;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;
    hps_cmd_t            cmd;
    hps_status_t         st;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            play_mode_reg   <= MODE_LOOP;
            loop_count_reg  <= LOOP_W'(1);
            span_reg        <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_COUNT: frame_count_reg <= pwdata[FCOUNT_W-1:0];
                REG_PLAY_MODE:   play_mode_reg   <= pwdata[1:0];
                REG_LOOP_COUNT:  loop_count_reg  <= pwdata[LOOP_W-1:0];
                REG_SPAN_TICKS:  span_reg        <= pwdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_COUNT: prdata = APB_DW'(frame_count_reg);
            REG_PLAY_MODE:   prdata = APB_DW'(play_mode_reg);
            REG_LOOP_COUNT:  prdata = APB_DW'(loop_count_reg);
            REG_SPAN_TICKS:  prdata = APB_DW'(span_reg);
            default:         prdata = '0;
        endcase
    end

    // oversized frame count clamps to the table depth
    assign active_n = (FCOUNT_W'(MAX_FRAMES) < frame_count_reg) ? N_W'(MAX_FRAMES)
                                                                : N_W'(frame_count_reg);

    hps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .req_type    (req_type),
        .frame_index (frame_index),
        .active_n    (active_n),
        .play_mode   (play_mode_reg),
        .st          (st),
        .cmd         (cmd)
    );

    hps_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .req_type        (req_type),
        .frame_index     (frame_index),
        .frame_ticks     (frame_ticks),
        .frame_levels    (frame_levels),
        .delta_ticks     (delta_ticks),
        .play_mode       (play_mode_reg),
        .loop_count      (loop_count_reg),
        .play_span_ticks (span_reg),
        .motor_levels    (motor_levels),
        .finished        (finished)
    );

endmodule : haptic_pattern_sequencer
`default_nettype wire

FILE: hw/rtl/hps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_ctrl: sequencing controller
// Accepts one item at a time, walks the frame table, runs the modulo steps
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module hps_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    input  wire logic [hps_pkg::REQ_W-1:0]   req_type,
    input  wire logic [hps_pkg::FIDX_W-1:0]  frame_index,
    input  wire logic [hps_pkg::N_W-1:0]     active_n,
    input  wire logic [1:0]                  play_mode,
    input  wire hps_pkg::hps_status_t        st,
    output hps_pkg::hps_cmd_t                cmd
);
    import hps_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WALK  = 10'b00_0000_0010,
        S_SEEK  = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_CHK   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_FEND  = 10'b00_0100_0000,
        S_LVRD  = 10'b00_1000_0000,
        S_LVSET = 10'b01_0000_0000,
        S_RESP  = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [N_W-1:0]    lim_reg, lim_next;
    logic              find_reg, find_next;
    logic [ADDR_W-1:0] lv_addr_reg, lv_addr_next;
    logic              out_valid_reg, out_valid_next;
    req_t              req_in;

    assign req_in    = req_t'(req_type);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        find_next      = find_reg;
        lv_addr_next   = lv_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.rd_addr    = cnt_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept   = 1'b1;
                    req_next     = req_in;
                    cnt_next     = '0;
                    find_next    = 1'b0;
                    lv_addr_next = '0;
                    case (req_in)
                        REQ_ADVANCE:
                        begin
                            cmd.clr_acc = 1'b1;
                            lim_next    = active_n;
                            state_next  = S_WALK;
                        end
                        REQ_STOP, REQ_RESTART:
                        begin
                            state_next = (active_n != '0) ? S_LVRD : S_RESP;
                        end
                        REQ_SEEK:
                        begin
                            if (N_W'(frame_index) < active_n)
                            begin
                                cmd.clr_acc  = 1'b1;
                                lim_next     = N_W'(frame_index);
                                lv_addr_next = ADDR_W'(frame_index);
                                state_next   = S_WALK;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            // one table read per cycle; the datapath consumes the read data in the next cycle
            S_WALK:
            begin
                if (cnt_reg < CNT_W'(lim_reg))
                begin
                    cmd.walk_rd   = 1'b1;
                    cmd.walk_find = find_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else if (find_reg)
                begin
                    state_next = S_FEND;
                end
                else if (req_reg == REQ_SEEK)
                begin
                    state_next = S_SEEK;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SEEK:
            begin
                cmd.seek_set = 1'b1;
                state_next   = S_LVRD;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHK;
            end
            // end-of-playback decisions
            S_CHK:
            begin
                if (active_n == '0)
                begin
                    cmd.set_silent  = 1'b1;
                    cmd.silent_done = 1'b1;
                    state_next      = S_RESP;
                end
                else if (st.total_zero)
                begin
                    cmd.set_silent  = 1'b1;
                    cmd.silent_done = (mode_t'(play_mode) != MODE_LOOP);
                    state_next      = S_RESP;
                end
                else if (st.past_end)
                begin
                    cmd.set_silent  = 1'b1;
                    cmd.silent_done = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            // one remainder bit per cycle
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(ELAPSED_W - 1))
                begin
                    cmd.find_init = 1'b1;
                    cnt_next      = '0;
                    lim_next      = active_n;
                    find_next     = 1'b1;
                    state_next    = S_WALK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FEND:
            begin
                cmd.found_take = 1'b1;
                state_next     = S_RESP;
            end
            S_LVRD:
            begin
                cmd.rd_addr = lv_addr_reg;
                state_next  = S_LVSET;
            end
            S_LVSET:
            begin
                cmd.lv_take = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= REQ_LOAD;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            find_reg      <= 1'b0;
            lv_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            find_reg      <= find_next;
            lv_addr_reg   <= lv_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : hps_ctrl
`default_nettype wire

FILE: hw/rtl/hps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_dp: sequencer datapath
// Frame tables, elapsed counter, tick sum, serial modulo, frame search and
// the output register.
// ----------------------------------------------------------------------------
module hps_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hps_pkg::hps_cmd_t             cmd,
    output hps_pkg::hps_status_t               st,
    input  wire logic [hps_pkg::REQ_W-1:0]     req_type,
    input  wire logic [hps_pkg::FIDX_W-1:0]    frame_index,
    input  wire logic [hps_pkg::TICK_W-1:0]    frame_ticks,
    input  wire logic [hps_pkg::LEVEL_W-1:0]   frame_levels,
    input  wire logic [hps_pkg::DELTA_W-1:0]   delta_ticks,
    input  wire logic [1:0]                    play_mode,
    input  wire logic [hps_pkg::LOOP_W-1:0]    loop_count,
    input  wire logic [hps_pkg::SPAN_W-1:0]    play_span_ticks,
    output logic [hps_pkg::LEVEL_W-1:0]        motor_levels,
    output logic                               finished
);
    import hps_pkg::*;

    logic [TICK_W-1:0]    tick_mem_reg [MAX_FRAMES];
    logic [LEVEL_W-1:0]   lev_mem_reg  [MAX_FRAMES];
    logic [TICK_W-1:0]    rd_tick_reg;
    logic [LEVEL_W-1:0]   rd_lev_reg;

    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 running_reg, running_next;
    logic [LEVEL_W-1:0]   levels_reg, levels_next;
    logic                 done_reg, done_next;
    logic                 issue_d_reg, find_d_reg, found_reg, found_next;

    logic [TOTAL_W-1:0]   acc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TOTAL_W-1:0]   rem_reg;
    logic [ELAPSED_W-1:0] quo_reg;
    logic [TOTAL_W-1:0]   cum_reg;
    logic [LEVEL_W-1:0]   lev_sel_reg;
    logic [LEVEL_W-1:0]   out_levels_reg;
    logic                 out_fin_reg;

    req_t                 req_in;
    logic [ELAPSED_W:0]   add_sum;
    logic [TOTAL_W:0]     div_try;
    logic [TOTAL_W-1:0]   rem_step;
    logic [TOTAL_W:0]     find_end;
    logic                 find_hit;

    assign req_in       = req_t'(req_type);
    assign motor_levels = out_levels_reg;
    assign finished     = out_fin_reg;

    // frame tables, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && req_in == REQ_LOAD)
        begin
            tick_mem_reg[ADDR_W'(frame_index)] <= frame_ticks;
            lev_mem_reg[ADDR_W'(frame_index)]  <= frame_levels;
        end
        rd_tick_reg <= tick_mem_reg[cmd.rd_addr];
        rd_lev_reg  <= lev_mem_reg[cmd.rd_addr];
    end

    // saturating advance
    assign add_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(delta_ticks);

    // restoring remainder step
    assign div_try  = {rem_reg, quo_reg[ELAPSED_W-1]};
    assign rem_step = (div_try >= {1'b0, acc_reg}) ? TOTAL_W'(div_try - {1'b0, acc_reg})
                                                   : TOTAL_W'(div_try);

    // frame window test
    assign find_end = {1'b0, cum_reg} + (TOTAL_W + 1)'(rd_tick_reg);
    assign find_hit = (rd_tick_reg != '0) && ({1'b0, rem_reg} < find_end);

    // end-of-playback status
    always_comb
    begin
        st.total_zero = (acc_reg == '0);
        case (mode_t'(play_mode))
            MODE_SINGLE: st.past_end = CMP_W'(elapsed_reg) >= CMP_W'(acc_reg);
            MODE_LOOP_N: st.past_end = (loop_count == '0)
                                       || (CMP_W'(elapsed_reg) >= CMP_W'(prod_reg));
            MODE_SPAN:   st.past_end = (play_span_ticks == '0)
                                       || (CMP_W'(elapsed_reg) >= CMP_W'(play_span_ticks));
            default:     st.past_end = 1'b0;
        endcase
    end

    // player state update
    always_comb
    begin
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        levels_next  = levels_reg;
        done_next    = done_reg;
        found_next   = found_reg;
        if (cmd.accept)
        begin
            case (req_in)
                REQ_ADVANCE:
                begin
                    if (running_reg)
                        elapsed_next = add_sum[ELAPSED_W] ? '1 : add_sum[ELAPSED_W-1:0];
                end
                REQ_PLAY:  running_next = 1'b1;
                REQ_PAUSE: running_next = 1'b0;
                REQ_STOP, REQ_RESTART:
                begin
                    running_next = (req_in == REQ_RESTART);
                    elapsed_next = '0;
                    levels_next  = '0;
                    done_next    = 1'b0;
                end
                default: ;
            endcase
        end
        if (cmd.seek_set)
        begin
            elapsed_next = ELAPSED_W'(acc_reg);
            done_next    = 1'b0;
        end
        if (cmd.set_silent)
        begin
            levels_next = '0;
            done_next   = cmd.silent_done;
        end
        if (cmd.lv_take)
            levels_next = rd_lev_reg;
        if (cmd.found_take)
        begin
            levels_next = lev_sel_reg;
            done_next   = 1'b0;
        end
        if (cmd.find_init)
            found_next = 1'b0;
        else if (issue_d_reg && find_d_reg && !found_reg && find_hit)
            found_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            levels_reg  <= '0;
            done_reg    <= 1'b0;
            issue_d_reg <= 1'b0;
            find_d_reg  <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            levels_reg  <= levels_next;
            done_reg    <= done_next;
            issue_d_reg <= cmd.walk_rd;
            find_d_reg  <= cmd.walk_find;
            found_reg   <= found_next;
        end
    end

    // working registers: sum, product, remainder, search, output
    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (issue_d_reg && !find_d_reg)
            acc_reg <= acc_reg + TOTAL_W'(rd_tick_reg);

        if (cmd.mul)
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(loop_count);

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= elapsed_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[ELAPSED_W-2:0], 1'b0};
        end

        if (cmd.find_init)
        begin
            cum_reg     <= '0;
            lev_sel_reg <= '0;
        end
        else if (issue_d_reg && find_d_reg && !found_reg)
        begin
            if (find_hit)
                lev_sel_reg <= rd_lev_reg;
            else
                cum_reg <= TOTAL_W'(find_end);
        end

        if (cmd.out_load)
        begin
            out_levels_reg <= levels_reg;
            out_fin_reg    <= done_reg;
        end
    end

endmodule : hps_dp
`default_nettype wire
